// ===== rtl/hdlc_style_byte_stuffing_framer_defines.svh =====
// Assertion macros shared by the framer RTL.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef HDLC_STYLE_BYTE_STUFFING_FRAMER_DEFINES_SVH
`define HDLC_STYLE_BYTE_STUFFING_FRAMER_DEFINES_SVH

// Clocked check, skipped while reset is high
`define HSF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define HSF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsf_pkg.sv =====
// Types and constants of the byte-stuffing framer.
// No dependencies; used by every module of the block.
`default_nettype none

package hsf_pkg;

  // byte slots of one frame piece, lowest slot goes out first
  localparam int SLOTS = 6;
  localparam int SLOT_OPEN  = 0;
  localparam int SLOT_ADDR  = 1;
  localparam int SLOT_CTRL  = 2;
  localparam int SLOT_HCS   = 3;
  localparam int SLOT_DATA  = 4;
  localparam int SLOT_CLOSE = 5;

  localparam logic [7:0] STUFF_XOR    = 8'h20;
  localparam logic [7:0] FLAG_RESET   = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET = 8'h7D;

  // configuration register indexes
  localparam logic [7:0] REG_FLAG   = 8'd0;
  localparam logic [7:0] REG_ESCAPE = 8'd1;

  // frame kinds carried on tuser
  localparam logic MODE_SUPERVISORY = 1'b0;
  localparam logic MODE_INFO        = 1'b1;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
  } hsf_cfg_t;

  // one classified item: which slots go out, which are escaped, their bytes
  typedef struct packed {
    logic [SLOTS-1:0]      present;
    logic [SLOTS-1:0]      stuffed;
    logic [SLOTS-1:0][7:0] bytes;
  } hsf_entry_t;

endpackage

`default_nettype wire

// ===== rtl/hsf_front.sv =====
// Front end: classifies one input word into the byte slots of its frame piece.
// Depends on hsf_pkg.
`default_nettype none

module hsf_front (
  input  wire logic              mode,
  input  wire logic [7:0]        frame_address,
  input  wire logic [7:0]        frame_control,
  input  wire logic [7:0]        payload_byte,
  input  wire logic              first_byte,
  input  wire logic              last_byte,
  input  wire hsf_pkg::hsf_cfg_t cfg,
  output hsf_pkg::hsf_entry_t    entry
);
  import hsf_pkg::*;

  logic [7:0] hcs;

  // byte needs escaping if it collides with flag or escape
  function automatic logic needs_stuff(input logic [7:0] b, input hsf_cfg_t c);
    needs_stuff = (b == c.flag) || (b == c.escape);
  endfunction

  assign hcs = frame_address ^ frame_control;

  always_comb begin
    entry.bytes[SLOT_OPEN]  = cfg.flag;
    entry.bytes[SLOT_ADDR]  = frame_address;
    entry.bytes[SLOT_CTRL]  = frame_control;
    entry.bytes[SLOT_HCS]   = hcs;
    entry.bytes[SLOT_DATA]  = payload_byte;
    entry.bytes[SLOT_CLOSE] = cfg.flag;
    entry.present = '0;
    entry.stuffed = '0;
    if (mode == MODE_SUPERVISORY) begin
      // full frame, nothing escaped, no payload
      entry.present[SLOT_OPEN]  = 1'b1;
      entry.present[SLOT_ADDR]  = 1'b1;
      entry.present[SLOT_CTRL]  = 1'b1;
      entry.present[SLOT_HCS]   = 1'b1;
      entry.present[SLOT_CLOSE] = 1'b1;
    end else begin
      entry.present[SLOT_OPEN]  = first_byte;
      entry.present[SLOT_ADDR]  = first_byte;
      entry.present[SLOT_CTRL]  = first_byte;
      entry.present[SLOT_HCS]   = first_byte;
      entry.present[SLOT_DATA]  = 1'b1;
      entry.present[SLOT_CLOSE] = last_byte;
      entry.stuffed[SLOT_ADDR]  = needs_stuff(frame_address, cfg);
      entry.stuffed[SLOT_CTRL]  = needs_stuff(frame_control, cfg);
      entry.stuffed[SLOT_HCS]   = needs_stuff(hcs, cfg);
      entry.stuffed[SLOT_DATA]  = needs_stuff(payload_byte, cfg);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsf_queue.sv =====
// Small FIFO of classified words between front end and byte sequencer.
// Depends on hsf_pkg and the assertion macro header.
`default_nettype none
`include "hdlc_style_byte_stuffing_framer_defines.svh"

module hsf_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire hsf_pkg::hsf_entry_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output hsf_pkg::hsf_entry_t      pop_data,
  output logic                     valid
);
  import hsf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hsf_entry_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = store[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `HSF_ASSERT_ALWAYS(a_count_bound, (rst || (count <= CNT_W'(DEPTH))), "queue count beyond depth")
  `HSF_ASSERT(a_empty_ptrs, ((count == '0) |-> (rd_ptr == wr_ptr)), "empty queue, pointers differ")

endmodule

`default_nettype wire

// ===== rtl/hsf_back.sv =====
// Back end: walks a word's slots and emits one line byte per cycle unless m_tready stalls.
// Depends on hsf_pkg and the assertion macro header.
`default_nettype none
`include "hdlc_style_byte_stuffing_framer_defines.svh"

module hsf_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hsf_pkg::hsf_cfg_t   cfg,
  input  wire logic                q_valid,
  input  wire hsf_pkg::hsf_entry_t q_data,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [7:0]               m_tdata,
  output logic                     m_tlast
);
  import hsf_pkg::*;

  hsf_entry_t       cur;
  logic [SLOTS-1:0] pend;
  logic             phase;      // 1: escape already sent, send the xored byte
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             adv;
  logic             busy;
  logic [SLOTS-1:0] low;
  logic [SLOTS-1:0] rest;
  logic [7:0]       sel_byte;
  logic             sel_stuffed;
  logic             half_done;
  logic             item_done;
  logic [7:0]       word_byte;

  assign adv  = !out_valid || m_tready;
  assign busy = (pend != '0);

  // current slot is the lowest pending one
  always_comb begin
    low         = pend & (~pend + SLOTS'(1));
    sel_byte    = '0;
    sel_stuffed = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low[i]) begin
        sel_byte    = sel_byte | cur.bytes[i];
        sel_stuffed = sel_stuffed | cur.stuffed[i];
      end
    end
  end

  assign rest      = pend & ~low;
  assign half_done = !sel_stuffed || phase;
  assign item_done = busy && half_done && (rest == '0);
  assign q_pop     = adv && (!busy || item_done) && q_valid;

  always_comb begin
    if (sel_stuffed && !phase) begin
      word_byte = cfg.escape;
    end else if (sel_stuffed) begin
      word_byte = sel_byte ^ STUFF_XOR;
    end else begin
      word_byte = sel_byte;
    end
  end

  // slot walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= '0;
      phase <= 1'b0;
    end else if (q_pop) begin
      pend  <= q_data.present;
      phase <= 1'b0;
    end else if (adv && busy) begin
      if (half_done) begin
        pend  <= rest;
        phase <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && busy) begin
      out_byte <= word_byte;
      out_last <= item_done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

  `HSF_ASSERT(a_phase_stuffed, ((busy && phase) |-> sel_stuffed), "second half on unstuffed slot")
  `HSF_ASSERT(a_escape_then_xor, ((adv && busy && sel_stuffed && !phase) |=> phase), "escape not followed by xored byte")
  `HSF_ASSERT(a_pend_present, ((pend & ~cur.present) == '0), "pending slot not in word")

endmodule

`default_nettype wire

// ===== rtl/hdlc_style_byte_stuffing_framer.sv =====
// Top level of the HDLC-style byte-stuffing framer: config registers and wiring.
// Depends on hsf_pkg, hsf_front, hsf_queue and hsf_back.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata address, control, payload; tuser mode, first; tlast
// m_*       out  m_tvalid/m_tready   tdata line byte; tlast last byte of the word's output
// cfg_*     in   cfg_valid/cfg_ready index 0 flag, 1 escape; other indexes ignored
//
// One line byte leaves per cycle from the output register while m_tready is high; a word
// produces 1 to 10 bytes, a payload byte alone 1 or 2.
// The queue lets the front take new words while the back is still sending.
// Synchronous reset clears control state and loads flag 0x7E and escape 0x7D.
// Output stalls hold the line byte; the input stalls only when the queue is full.
`default_nettype none

module hdlc_style_byte_stuffing_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] frame_address, [15:8] frame_control,
                                      // [23:16] payload_byte
  input  wire logic [1:0]  s_tuser,   // [0] mode, [1] first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast,   // run_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import hsf_pkg::*;

  hsf_cfg_t   cfg;
  hsf_entry_t front_entry;
  hsf_entry_t q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag   <= FLAG_RESET;
      cfg.escape <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLAG:   cfg.flag   <= cfg_data;
        REG_ESCAPE: cfg.escape <= cfg_data;
        default:    ;
      endcase
    end
  end

  hsf_front u_front (
    .mode          (s_tuser[0]),
    .frame_address (s_tdata[7:0]),
    .frame_control (s_tdata[15:8]),
    .payload_byte  (s_tdata[23:16]),
    .first_byte    (s_tuser[1]),
    .last_byte     (s_tlast),
    .cfg           (cfg),
    .entry         (front_entry)
  );

  hsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .valid     (q_valid)
  );

  hsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/hsf_frame_checker.sv =====
// Checker for the byte-stuffing framer: watches the config, input and line channels,
// predicts the line bytes of every accepted word and compares them in order.
// Depends on hsf_pkg for register indexes, frame kinds and reset values.
`timescale 1ns / 100ps

module hsf_frame_checker
  import hsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] frame_address, [15:8] frame_control,
                                 // [23:16] payload_byte
  input  logic [1:0]  s_tuser,   // [0] mode, [1] first_byte
  input  logic        s_tlast,   // last_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] out_byte
  input  logic        m_tlast,   // run_end
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          waiting,
  output int          bytes_checked
);

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
  } line_byte_t;

  line_byte_t line_q[$];
  logic [7:0] flag_val;
  logic [7:0] escape_val;
  logic [7:0] seq [0:9];
  int         seq_n;

  task automatic emit(input logic [7:0] b);
    seq[seq_n] = b;
    seq_n++;
  endtask

  // flag or escape goes out as escape, byte ^ 0x20
  task automatic emit_stuffed(input logic [7:0] b);
    if (b == flag_val || b == escape_val) begin
      emit(escape_val);
      emit(b ^ STUFF_XOR);
    end else begin
      emit(b);
    end
  endtask

  // Line bytes one word produces, queued with run_end on the last one
  task automatic frame_word(input logic mode, input logic [7:0] addr, input logic [7:0] ctrl,
                            input logic [7:0] data, input logic first, input logic last);
    logic [7:0] hcs;
    line_byte_t lb;
    hcs = addr ^ ctrl;
    seq_n = 0;
    if (mode == MODE_SUPERVISORY) begin
      // supervisory header is never stuffed
      emit(flag_val);
      emit(addr);
      emit(ctrl);
      emit(hcs);
      emit(flag_val);
    end else begin
      if (first) begin
        emit(flag_val);
        emit_stuffed(addr);
        emit_stuffed(ctrl);
        emit_stuffed(hcs);
      end
      emit_stuffed(data);
      if (last) emit(flag_val);
    end
    for (int i = 0; i < seq_n; i++) begin
      lb.value = seq[i];
      lb.run_end = (i == seq_n - 1);
      line_q.push_back(lb);
    end
  endtask

  // Track config, check line bytes, queue expectations
  always @(posedge clk) begin : watch
    line_byte_t want;
    logic bad;
    if (rst) begin
      flag_val <= FLAG_RESET;
      escape_val <= ESCAPE_RESET;
      line_q.delete();
      mismatches <= 0;
      waiting <= 0;
      bytes_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FLAG) flag_val <= cfg_data;
        else if (cfg_index == REG_ESCAPE) escape_val <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        bad = 1'b0;
        if (line_q.size() == 0) begin
          $display("%0t: unexpected line word: expected none, got byte %h run_end %b",
                   $time, m_tdata, m_tlast);
          bad = 1'b1;
        end else begin
          want = line_q.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: out_byte mismatch: expected %h, got %h", $time, want.value, m_tdata);
            bad = 1'b1;
          end
          if (m_tlast !== want.run_end) begin
            $display("%0t: run_end mismatch: expected %b, got %b", $time, want.run_end, m_tlast);
            bad = 1'b1;
          end
        end
        if (bad) mismatches <= mismatches + 1;
        bytes_checked <= bytes_checked + 1;
      end
      if (s_tvalid && s_tready)
        frame_word(s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser[1], s_tlast);
      waiting <= line_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the framer testbench: clock, reset, config writes, input words and output stalls.
// Depends on hsf_pkg, the framer RTL and hsf_frame_checker, which does all comparing.
`timescale 1ns / 100ps

module tb;
  import hsf_pkg::*;

  localparam int         HOLD_CYCLES = 60;
  // indexes past the two registers, written to show they are ignored
  localparam logic [7:0] REG_SPARE   = 8'd2;
  localparam logic [7:0] REG_TOP     = 8'hFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int          mismatches;
  int          waiting;
  int          bytes_checked;
  int          words_sent = 0;
  int          settings_used = 1;
  bit          calm = 1'b0;
  bit          long_hold = 1'b0;
  logic [7:0]  cur_flag = FLAG_RESET;
  logic [7:0]  cur_escape = ESCAPE_RESET;

  hdlc_style_byte_stuffing_framer i_dut (.*);

  hsf_frame_checker i_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Line side: short random stalls, one long hold-off on request, none when calm
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // One input word, with an occasional gap in front of it
  task automatic send_word(input logic mode, input logic [7:0] addr, input logic [7:0] ctrl,
                           input logic [7:0] data, input logic first, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {data, ctrl, addr};
    s_tuser <= {first, mode};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Often the current flag or escape, so stuffing is hit a lot
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return cur_flag;
      1: return cur_escape;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly whole information frames; some supervisory, stray and unclosed ones
  task automatic send_random_frame();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      send_word(MODE_SUPERVISORY, pick_byte(), pick_byte(), pick_byte(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (kind == 2) begin
      send_word(MODE_INFO, pick_byte(), pick_byte(), pick_byte(), 1'b0,
                1'($urandom_range(0, 1)));
    end else begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        send_word(MODE_INFO, pick_byte(), pick_byte(), pick_byte(), i == 0,
                  (i == len - 1) && (kind != 3));
    end
  endtask

  task automatic send_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) send_random_frame();
  endtask

  // Stop offering words until every line byte has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  task automatic set_reg(input logic [7:0] index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(input logic [7:0] flag, input logic [7:0] escape);
    drain();
    set_reg(REG_FLAG, flag);
    set_reg($urandom_range(0, 1) ? REG_SPARE : REG_TOP, 8'($urandom_range(0, 255)));
    set_reg(REG_ESCAPE, escape);
    cfg_valid <= 1'b0;
    cur_flag = flag;
    cur_escape = escape;
    settings_used++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: supervisory extremes, header bytes equal to flag/escape left alone
    send_word(MODE_SUPERVISORY, 8'hFF, 8'h00, 8'hA5, 1'b1, 1'b1);
    send_word(MODE_SUPERVISORY, 8'h7E, 8'h7D, 8'h00, 1'b0, 1'b0);
    send_word(MODE_SUPERVISORY, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1);
    // single-word frame with stuffed address, control and payload
    send_word(MODE_INFO, 8'h7E, 8'h7D, 8'h7E, 1'b1, 1'b1);
    // header check lands on the flag; then middle, closing and stray payload bytes
    send_word(MODE_INFO, 8'h7D, 8'h03, 8'h00, 1'b1, 1'b0);
    send_word(MODE_INFO, 8'hFF, 8'h00, 8'h7D, 1'b0, 1'b0);
    send_word(MODE_INFO, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1);
    send_word(MODE_INFO, 8'h12, 8'h34, 8'h5E, 1'b0, 1'b0);
    send_word(MODE_INFO, 8'h12, 8'h34, 8'h7E, 1'b0, 1'b1);
    send_random(15);

    // flag 0x00, escape 0xFF: longest frame, then a long line stall while words keep coming
    load_setting(8'h00, 8'hFF);
    send_word(MODE_INFO, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_word(MODE_INFO, pick_byte(), pick_byte(), pick_byte(), i == 0, i == 11);
    send_random(15);

    load_setting(8'hFF, 8'h00);
    send_word(MODE_INFO, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
    send_random(15);

    // flag equal to escape: each match is stuffed once
    load_setting(8'h55, 8'h55);
    send_word(MODE_INFO, 8'h55, 8'h20, 8'h55, 1'b1, 1'b0);
    send_word(MODE_INFO, 8'h00, 8'h00, 8'h75, 1'b0, 1'b1);
    send_random(15);

    // back to reset values, no idling on either side
    load_setting(FLAG_RESET, ESCAPE_RESET);
    calm = 1'b1;
    send_random(15);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input words under %0d flag/escape settings, %0d line bytes checked,",
             words_sent, settings_used, bytes_checked);
    $display("with maximum-length stuffed frames, a long line stall and ignored register indexes.");
    if (mismatches == 0 && waiting == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
